FILE: sv/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants for the committee block assignment engine.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int unsigned MAX_CANDIDATES = 16;
  localparam int unsigned MAX_VOTERS     = 64;
  localparam int unsigned MAX_COMMITTEE  = 8;

  localparam int unsigned CAND_W  = 4;
  localparam int unsigned VOTER_W = 6;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned RANK_W  = 5;
  localparam int unsigned COST_W  = 10;
  localparam int unsigned NC_W    = 5;
  localparam int unsigned NV_W    = 7;
  localparam int unsigned K_W     = 4;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned RANK_A_W = CAND_W + VOTER_W;
  localparam int unsigned TAB_A_W  = CAND_W + SLOT_W;

  localparam logic [COST_W-1:0] COST_MAX = 10'd1023;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SOLVE = 1'b1
  } op_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_NUM_CAND   = 2'd0,
    CFG_NUM_VOTERS = 2'd1,
    CFG_COMMITTEE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MARK_UNSET = 2'd0,
    MARK_TAKE  = 2'd1,
    MARK_SKIP  = 2'd2,
    MARK_DIAG  = 2'd3
  } mark_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_DIV, S_RA, S_RB, S_CMP, S_SWR,
    S_OA, S_RK, S_ACC, S_PREV, S_WR, S_TBI, S_TBR, S_TBC, S_EMIT
  } state_e;

  typedef enum logic [4:0] {
    ST_NONE, ST_LOAD, ST_INIT, ST_DIV, ST_RA, ST_RB, ST_CMP, ST_SWR,
    ST_OA, ST_RK, ST_ACC, ST_PREV, ST_WR, ST_TBI, ST_TBR, ST_TBC,
    ST_EMIT, ST_ERR
  } step_e;

  typedef struct packed {
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic bad_cfg;
    logic div_done;
    logic cmp_done;
    logic b_last;
    logic a_last;
    logic t_last;
    logic i_last;
    logic j_last;
    logic tb_skip;
    logic j_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/cba_ram.sv
// ----------------------------------------------------------------------------
// cba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cba_ctrl.sv
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer for load, block size, sort, cost table, traceback, result and error phases.
// ----------------------------------------------------------------------------
module cba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          op_i,
  output logic          in_stall_o,
  input  cba_pkg::sts_t sts_i,
  output cba_pkg::cmd_t cmd_o
);

  cba_pkg::state_e state_q, state_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != cba_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.step = cba_pkg::ST_NONE;
    unique case (state_q)
      cba_pkg::S_IDLE: begin
        if (accept) begin
          if (op_i == cba_pkg::OP_LOAD) begin
            cmd_o.step = cba_pkg::ST_LOAD;
          end else if (sts_i.bad_cfg) begin
            state_d = cba_pkg::S_ERR;
          end else begin
            cmd_o.step = cba_pkg::ST_INIT;
            state_d    = cba_pkg::S_DIV;
          end
        end
      end
      cba_pkg::S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.step = cba_pkg::ST_ERR;
          state_d    = cba_pkg::S_IDLE;
        end
      end
      cba_pkg::S_DIV: begin
        cmd_o.step = cba_pkg::ST_DIV;
        if (sts_i.div_done) state_d = cba_pkg::S_RA;
      end
      cba_pkg::S_RA: begin
        cmd_o.step = cba_pkg::ST_RA;
        state_d    = cba_pkg::S_RB;
      end
      cba_pkg::S_RB: begin
        cmd_o.step = cba_pkg::ST_RB;
        state_d    = cba_pkg::S_CMP;
      end
      cba_pkg::S_CMP: begin
        cmd_o.step = cba_pkg::ST_CMP;
        state_d    = (sts_i.cmp_done && sts_i.b_last) ? cba_pkg::S_SWR : cba_pkg::S_RA;
      end
      cba_pkg::S_SWR: begin
        cmd_o.step = cba_pkg::ST_SWR;
        state_d    = sts_i.a_last ? cba_pkg::S_OA : cba_pkg::S_RA;
      end
      cba_pkg::S_OA: begin
        cmd_o.step = cba_pkg::ST_OA;
        state_d    = cba_pkg::S_RK;
      end
      cba_pkg::S_RK: begin
        cmd_o.step = cba_pkg::ST_RK;
        state_d    = cba_pkg::S_ACC;
      end
      cba_pkg::S_ACC: begin
        cmd_o.step = cba_pkg::ST_ACC;
        state_d    = sts_i.t_last ? cba_pkg::S_PREV : cba_pkg::S_OA;
      end
      cba_pkg::S_PREV: begin
        cmd_o.step = cba_pkg::ST_PREV;
        state_d    = cba_pkg::S_WR;
      end
      cba_pkg::S_WR: begin
        cmd_o.step = cba_pkg::ST_WR;
        state_d    = (sts_i.i_last && sts_i.j_last) ? cba_pkg::S_TBI : cba_pkg::S_OA;
      end
      cba_pkg::S_TBI: begin
        cmd_o.step = cba_pkg::ST_TBI;
        state_d    = cba_pkg::S_TBR;
      end
      cba_pkg::S_TBR: begin
        cmd_o.step = cba_pkg::ST_TBR;
        state_d    = cba_pkg::S_TBC;
      end
      cba_pkg::S_TBC: begin
        cmd_o.step = cba_pkg::ST_TBC;
        state_d    = (!sts_i.tb_skip && sts_i.j_zero) ? cba_pkg::S_EMIT : cba_pkg::S_TBR;
      end
      cba_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.step = cba_pkg::ST_EMIT;
          if (sts_i.j_last) state_d = cba_pkg::S_IDLE;
        end
      end
      default: state_d = cba_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: sv/cba_dp.sv
// ----------------------------------------------------------------------------
// cba_dp
// Datapath: configuration, rank/order/cost/mark stores, counters and output.
// ----------------------------------------------------------------------------
module cba_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cba_pkg::CFG_A_W-1:0]     cfg_addr_i,
  input  logic [cba_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic [cba_pkg::CAND_W-1:0]      cand_index_i,
  input  logic [cba_pkg::VOTER_W-1:0]     voter_index_i,
  input  logic [cba_pkg::RANK_W-1:0]      rank_value_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [cba_pkg::SLOT_W-1:0]      slot_o,
  output logic [cba_pkg::CAND_W-1:0]      chosen_candidate_o,
  output logic [cba_pkg::COST_W-1:0]      total_cost_o,
  output logic                            error_flag_o,
  output logic                            last_o,
  input  cba_pkg::cmd_t                   cmd_i,
  output cba_pkg::sts_t                   sts_o
);

  logic [cba_pkg::NC_W-1:0]    nc_cfg_q, nc;
  logic [cba_pkg::NV_W-1:0]    nv_cfg_q, nv;
  logic [cba_pkg::K_W-1:0]     k_q;

  logic [cba_pkg::NV_W-1:0]    rem_q, blk_q;
  logic [cba_pkg::VOTER_W-1:0] a_q, b_q, pos_q, t_q, base_q;
  logic [cba_pkg::CAND_W-1:0]  c_q, i_q, tc_q;
  logic [cba_pkg::SLOT_W-1:0]  j_q;
  logic [cba_pkg::RANK_W-1:0]  ra_q;
  logic [cba_pkg::COST_W-1:0]  acc_q, cur_q;
  logic [cba_pkg::CAND_W-1:0]  pick_q [cba_pkg::MAX_COMMITTEE];

  logic                        out_valid_q;
  logic [cba_pkg::SLOT_W-1:0]  slot_q;
  logic [cba_pkg::CAND_W-1:0]  cand_q;
  logic [cba_pkg::COST_W-1:0]  total_q;
  logic                        err_q, last_q;

  logic                          rank_we;
  logic [cba_pkg::RANK_A_W-1:0]  rank_waddr, rank_raddr;
  logic [cba_pkg::RANK_W-1:0]    rank_rd;
  logic                          ord_we;
  logic [cba_pkg::VOTER_W-1:0]   ord_raddr, ord_rd;
  logic                          tab_we;
  logic [cba_pkg::TAB_A_W-1:0]   tab_waddr, cost_raddr, mark_raddr;
  logic [cba_pkg::COST_W-1:0]    cost_rd, cost_new;
  logic [1:0]                    mark_rd, mark_new;

  logic                          differ, b_first, cmp_done, c_last;
  logic [cba_pkg::RANK_W-1:0]    dec;
  logic [cba_pkg::COST_W:0]      acc_sum, take_sum;
  logic [cba_pkg::COST_W-1:0]    acc_sat, take;
  logic                          diag, tb_skip;
  logic [cba_pkg::NV_W-1:0]      t_ext;
  logic [cba_pkg::CAND_W-1:0]    i_m1;
  logic [cba_pkg::SLOT_W-1:0]    j_m1;

  always_comb begin
    nc = (nc_cfg_q > cba_pkg::NC_W'(cba_pkg::MAX_CANDIDATES)) ?
         cba_pkg::NC_W'(cba_pkg::MAX_CANDIDATES) : nc_cfg_q;
    nv = (nv_cfg_q > cba_pkg::NV_W'(cba_pkg::MAX_VOTERS)) ?
         cba_pkg::NV_W'(cba_pkg::MAX_VOTERS) : nv_cfg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_cfg_q <= cba_pkg::NC_W'(16);
      nv_cfg_q <= cba_pkg::NV_W'(64);
      k_q      <= cba_pkg::K_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cba_pkg::CFG_NUM_CAND:   nc_cfg_q <= cfg_wdata_i[cba_pkg::NC_W-1:0];
        cba_pkg::CFG_NUM_VOTERS: nv_cfg_q <= cfg_wdata_i;
        cba_pkg::CFG_COMMITTEE:  k_q      <= cfg_wdata_i[cba_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  // voter compare
  assign differ   = (rank_rd != ra_q);
  assign c_last   = ({1'b0, c_q} == nc - 1'b1);
  assign b_first  = differ ? (rank_rd < ra_q) : (c_last && (b_q < a_q));
  assign cmp_done = differ || c_last;

  // block cost accumulate
  assign dec     = (rank_rd == '0) ? '0 : rank_rd - 1'b1;
  assign acc_sum = {1'b0, acc_q} + (cba_pkg::COST_W + 1)'(dec);
  assign acc_sat = acc_sum[cba_pkg::COST_W] ? cba_pkg::COST_MAX : acc_sum[cba_pkg::COST_W-1:0];

  // table entry
  assign take_sum = {1'b0, acc_q} + {1'b0, cost_rd};
  always_comb begin
    if (j_q == '0) begin
      take = acc_q;
    end else begin
      take = take_sum[cba_pkg::COST_W] ? cba_pkg::COST_MAX : take_sum[cba_pkg::COST_W-1:0];
    end
    diag = (i_q == {1'b0, j_q});
    if (diag) begin
      cost_new = take;
      mark_new = (j_q == '0) ? cba_pkg::MARK_TAKE : cba_pkg::MARK_DIAG;
    end else begin
      cost_new = (take <= cur_q) ? take : cur_q;
      mark_new = (take > cur_q) ? cba_pkg::MARK_SKIP : cba_pkg::MARK_TAKE;
    end
  end

  assign tb_skip = (tc_q > {1'b0, j_q}) && (mark_rd == cba_pkg::MARK_SKIP);
  assign t_ext   = {1'b0, t_q};
  assign i_m1    = i_q - 1'b1;
  assign j_m1    = j_q - 1'b1;

  // store ports
  always_comb begin
    rank_we    = (cmd_i.step == cba_pkg::ST_LOAD);
    rank_waddr = {cand_index_i, voter_index_i};
    unique case (cmd_i.step)
      cba_pkg::ST_RA: rank_raddr = {c_q, a_q};
      cba_pkg::ST_RB: rank_raddr = {c_q, b_q};
      default:        rank_raddr = {i_q, ord_rd};
    endcase
    ord_we     = (cmd_i.step == cba_pkg::ST_SWR);
    ord_raddr  = base_q + t_q;
    tab_we     = (cmd_i.step == cba_pkg::ST_WR);
    tab_waddr  = {i_q, j_q};
    cost_raddr = {i_m1, j_m1};
    mark_raddr = {tc_q, j_q};
  end

  cba_ram #(.WIDTH(cba_pkg::RANK_W), .DEPTH(cba_pkg::MAX_CANDIDATES * cba_pkg::MAX_VOTERS))
    u_rank (.clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_value_i),
            .raddr_i(rank_raddr), .rdata_o(rank_rd));

  cba_ram #(.WIDTH(cba_pkg::VOTER_W), .DEPTH(cba_pkg::MAX_VOTERS))
    u_order (.clk_i, .we_i(ord_we), .waddr_i(pos_q), .wdata_i(a_q),
             .raddr_i(ord_raddr), .rdata_o(ord_rd));

  cba_ram #(.WIDTH(cba_pkg::COST_W), .DEPTH(cba_pkg::MAX_CANDIDATES * cba_pkg::MAX_COMMITTEE))
    u_cost (.clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(cost_new),
            .raddr_i(cost_raddr), .rdata_o(cost_rd));

  cba_ram #(.WIDTH(2), .DEPTH(cba_pkg::MAX_CANDIDATES * cba_pkg::MAX_COMMITTEE))
    u_mark (.clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(mark_new),
            .raddr_i(mark_raddr), .rdata_o(mark_rd));

  // counters
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.step)
      cba_pkg::ST_INIT: begin
        rem_q  <= nv;
        blk_q  <= '0;
        a_q    <= '0;
        b_q    <= '0;
        c_q    <= '0;
        pos_q  <= '0;
        i_q    <= '0;
        j_q    <= '0;
        t_q    <= '0;
        base_q <= '0;
        acc_q  <= '0;
      end
      cba_pkg::ST_DIV: begin
        if (rem_q >= cba_pkg::NV_W'(k_q)) begin
          rem_q <= rem_q - cba_pkg::NV_W'(k_q);
          blk_q <= blk_q + 1'b1;
        end
      end
      cba_pkg::ST_RB: ra_q <= rank_rd;
      cba_pkg::ST_CMP: begin
        if (cmp_done) begin
          pos_q <= pos_q + cba_pkg::VOTER_W'(b_first);
          c_q   <= '0;
          b_q   <= b_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
      cba_pkg::ST_SWR: begin
        a_q   <= a_q + 1'b1;
        b_q   <= '0;
        c_q   <= '0;
        pos_q <= '0;
      end
      cba_pkg::ST_ACC: begin
        acc_q <= acc_sat;
        t_q   <= t_q + 1'b1;
      end
      cba_pkg::ST_WR: begin
        cur_q <= cost_new;
        t_q   <= '0;
        acc_q <= '0;
        if ({1'b0, i_q} == nc - 1'b1) begin
          j_q    <= j_q + 1'b1;
          i_q    <= cba_pkg::CAND_W'(j_q) + 1'b1;
          base_q <= base_q + blk_q[cba_pkg::VOTER_W-1:0];
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      cba_pkg::ST_TBI: begin
        tc_q <= cba_pkg::CAND_W'(nc - 1'b1);
        j_q  <= cba_pkg::SLOT_W'(k_q - 1'b1);
      end
      cba_pkg::ST_TBC: begin
        if (tb_skip) begin
          tc_q <= tc_q - 1'b1;
        end else begin
          pick_q[j_q] <= tc_q;
          tc_q        <= (tc_q != '0) ? tc_q - 1'b1 : '0;
          if (j_q != '0) j_q <= j_q - 1'b1;
        end
      end
      cba_pkg::ST_EMIT: j_q <= j_q + 1'b1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step == cba_pkg::ST_EMIT || cmd_i.step == cba_pkg::ST_ERR) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step == cba_pkg::ST_EMIT) begin
      slot_q  <= j_q;
      cand_q  <= pick_q[j_q];
      total_q <= cur_q;
      err_q   <= 1'b0;
      last_q  <= ({1'b0, j_q} == k_q - 1'b1);
    end else if (cmd_i.step == cba_pkg::ST_ERR) begin
      slot_q  <= '0;
      cand_q  <= '0;
      total_q <= '0;
      err_q   <= 1'b1;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign slot_o             = slot_q;
  assign chosen_candidate_o = cand_q;
  assign total_cost_o       = total_q;
  assign error_flag_o       = err_q;
  assign last_o             = last_q;

  always_comb begin
    sts_o.bad_cfg  = (k_q == '0) || (k_q > cba_pkg::K_W'(cba_pkg::MAX_COMMITTEE)) ||
                     ({1'b0, k_q} > nc) || (cba_pkg::NV_W'(k_q) > nv);
    sts_o.div_done = (rem_q < cba_pkg::NV_W'(k_q));
    sts_o.cmp_done = cmp_done;
    sts_o.b_last   = ({1'b0, b_q} == nv - 1'b1);
    sts_o.a_last   = ({1'b0, a_q} == nv - 1'b1);
    sts_o.t_last   = (t_ext == blk_q - 1'b1);
    sts_o.i_last   = ({1'b0, i_q} == nc - 1'b1);
    sts_o.j_last   = ({1'b0, j_q} == k_q - 1'b1);
    sts_o.tb_skip  = tb_skip;
    sts_o.j_zero   = (j_q == '0);
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == cba_pkg::ST_EMIT || cmd_i.step == cba_pkg::ST_ERR) |-> sts_o.out_free)
    else $error("result loaded while output register busy");
  a_wr_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == cba_pkg::ST_WR) |-> (i_q >= {1'b0, j_q}))
    else $error("table entry above diagonal written");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == cba_pkg::ST_SWR) |-> ({1'b0, pos_q} < nv))
    else $error("sorted position out of range");
  a_tb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == cba_pkg::ST_TBC && !tb_skip) |-> (tc_q >= {1'b0, j_q}))
    else $error("traceback candidate below slot");
`endif

endmodule

FILE: sv/committee_block_assignment_dp.sv
// ----------------------------------------------------------------------------
// committee_block_assignment_dp
// Committee selection by sorted voter blocks and a min-cost assignment table.
//
// Input channel (in_valid_i / in_stall_o): a load transaction (op 0) writes
// one rank and gives no result; loads may follow every cycle.
// A solve transaction (op 1) stalls the input until its results are queued.
// Output channel (out_valid_o / out_stall_i): one result per committee slot
// in ascending order, last_o on the final one; a bad committee size gives a
// single result with error_flag_o set. A result sits in the output register
// while the receiver stalls, and the sequencer waits for it to drain.
// A solve finds the block size nv/k by repeated subtraction, runs a stable
// rank sort over the single rank memory read port, sums a voter block for
// each table entry and ends with a traceback. Configuration must be written
// only while idle; the block itself does not enforce it.
// Reset sets 16 candidates, 64 voters, committee size 1 and empties the
// output register; rank contents are undefined until loaded.
// ----------------------------------------------------------------------------
module committee_block_assignment_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cba_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  logic [cba_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [cba_pkg::CAND_W-1:0]    cand_index_i,
  input  logic [cba_pkg::VOTER_W-1:0]   voter_index_i,
  input  logic [cba_pkg::RANK_W-1:0]    rank_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cba_pkg::SLOT_W-1:0]    slot_o,
  output logic [cba_pkg::CAND_W-1:0]    chosen_candidate_o,
  output logic [cba_pkg::COST_W-1:0]    total_cost_o,
  output logic                          error_flag_o,
  output logic                          last_o
);

  cba_pkg::cmd_t cmd;
  cba_pkg::sts_t sts;

  cba_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .op_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  cba_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .cand_index_i,
    .voter_index_i,
    .rank_value_i,
    .out_stall_i,
    .out_valid_o,
    .slot_o,
    .chosen_candidate_o,
    .total_cost_o,
    .error_flag_o,
    .last_o,
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule
